>>> src/cfse_pkg.sv
// ----------------------------------------------------------------------------
// cfse_pkg
// shared types, opcodes and helper functions for the clock field set editor
// ----------------------------------------------------------------------------
`default_nettype none

package cfse_pkg;

    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_NEXT    = 3'd1,
        OP_INC     = 3'd2,
        OP_DEC     = 3'd3,
        OP_CONFIRM = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        FLD_NONE    = 3'd0,
        FLD_YEAR    = 3'd1,
        FLD_MONTH   = 3'd2,
        FLD_DAY     = 3'd3,
        FLD_WEEKDAY = 3'd4,
        FLD_HOUR    = 3'd5,
        FLD_MINUTE  = 3'd6,
        FLD_SECOND  = 3'd7
    } field_sel_t;

    localparam int unsigned WrapW = 7;

    localparam logic [6:0] YearMax    = 7'd99;
    localparam logic [6:0] MonthMin   = 7'd1;
    localparam logic [6:0] MonthMax   = 7'd12;
    localparam logic [6:0] DayMin     = 7'd1;
    localparam logic [6:0] WeekdayMin = 7'd1;
    localparam logic [6:0] WeekdayMax = 7'd7;
    localparam logic [6:0] HourMax    = 7'd23;
    localparam logic [6:0] MinSecMax  = 7'd59;

    // one input item as held in the input register
    typedef struct packed {
        logic [2:0] opcode;
        logic [5:0] load_seconds;
        logic [5:0] load_minutes;
        logic [4:0] load_hours;
        logic [4:0] load_day;
        logic [3:0] load_month;
        logic [2:0] load_weekday;
        logic [6:0] load_year;
    } item_t;

    // editor state, shown directly on the result fields
    typedef struct packed {
        logic [2:0] cursor;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [4:0] day;
        logic [3:0] month;
        logic [2:0] weekday;
        logic [6:0] year;
    } fields_t;

    // per-item side results that go into the result register
    typedef struct packed {
        logic       commit;
        logic [7:0] display_address;
    } side_t;

    // wrapping step in lo..hi; out-of-range goes to lo (up) or hi (down)
    function automatic logic [WrapW-1:0] wrap_step(
        input logic [WrapW-1:0] v,
        input logic [WrapW-1:0] lo,
        input logic [WrapW-1:0] hi,
        input logic             up
    );
        logic [WrapW-1:0] r;
        if (up)
        begin
            r = (v >= hi || v < lo) ? lo : v + 1'b1;
        end
        else
        begin
            r = (v <= lo || v > hi) ? hi : v - 1'b1;
        end
        return r;
    endfunction

    // days in month, no leap-year rule
    function automatic logic [WrapW-1:0] month_length(input logic [3:0] m);
        logic [WrapW-1:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 7'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 7'd30;
            default:                                    r = 7'd29;
        endcase
        return r;
    endfunction

    // display cursor command for the selected field
    function automatic logic [7:0] cursor_address(input logic [2:0] c);
        logic [7:0] r;
        unique case (field_sel_t'(c))
            FLD_NONE:    r = 8'h00;
            FLD_YEAR:    r = 8'h83;
            FLD_MONTH:   r = 8'h86;
            FLD_DAY:     r = 8'h89;
            FLD_WEEKDAY: r = 8'h8F;
            FLD_HOUR:    r = 8'hC1;
            FLD_MINUTE:  r = 8'hC4;
            FLD_SECOND:  r = 8'hC7;
            default:     r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/clock_field_set_editor.sv
// ----------------------------------------------------------------------------
// clock_field_set_editor
// time-setting editor for a calendar clock with field cursor and commit
// ----------------------------------------------------------------------------
// Each key item gives one result item. An accepted item is held in the input
// register until the update logic moves it into the result register and the
// field registers together, so out_valid rises once the held item crosses over,
// and a new item is taken every cycle while results are consumed.
// The field registers feed the result field ports directly; they only change
// when the result register reloads, so a stalled result holds steady. Opcode
// 0 loads all seven fields as given (no range check) and deselects the
// cursor, 1 steps the cursor 1..7 and around, 2 and 3 wrap the selected field
// within its range (day range follows the month, February always 29 days),
// 4 raises commit for that one result and deselects the cursor. Opcodes 5..7
// change nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_field_set_editor (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] opcode,
    input  wire logic [5:0] load_seconds,
    input  wire logic [5:0] load_minutes,
    input  wire logic [4:0] load_hours,
    input  wire logic [4:0] load_day,
    input  wire logic [3:0] load_month,
    input  wire logic [2:0] load_weekday,
    input  wire logic [6:0] load_year,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      cursor_field,
    output logic [5:0]      seconds,
    output logic [5:0]      minutes,
    output logic [4:0]      hours,
    output logic [4:0]      day,
    output logic [3:0]      month,
    output logic [2:0]      weekday,
    output logic [6:0]      year,
    output logic [7:0]      display_address,
    output logic            commit
);

    cfse_pkg::item_t   item_in;
    cfse_pkg::item_t   item;
    cfse_pkg::fields_t fields;
    cfse_pkg::side_t   side_next;
    cfse_pkg::side_t   side;
    logic              item_valid;
    logic              advance;

    // gather the input ports into one item
    assign item_in.opcode       = opcode;
    assign item_in.load_seconds = load_seconds;
    assign item_in.load_minutes = load_minutes;
    assign item_in.load_hours   = load_hours;
    assign item_in.load_day     = load_day;
    assign item_in.load_month   = load_month;
    assign item_in.load_weekday = load_weekday;
    assign item_in.load_year    = load_year;

    // input register
    cfse_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item)
    );

    // field registers and update logic
    cfse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item),
        .fields    (fields),
        .side_next (side_next)
    );

    // result register, decides when an item crosses over
    cfse_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .side_next  (side_next),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .side       (side)
    );

    // result fields come straight from the state
    assign cursor_field    = fields.cursor;
    assign seconds         = fields.seconds;
    assign minutes         = fields.minutes;
    assign hours           = fields.hours;
    assign day             = fields.day;
    assign month           = fields.month;
    assign weekday         = fields.weekday;
    assign year            = fields.year;
    assign display_address = side.display_address;
    assign commit          = side.commit;

    // a commit always leaves the cursor deselected
    a_commit_clears_cursor: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && commit |-> cursor_field == cfse_pkg::FLD_NONE
    ) else $error("commit with a field still selected");

    // display address is zero exactly when no field is selected
    a_addr_matches_cursor: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((cursor_field == cfse_pkg::FLD_NONE) == (display_address == 8'h00))
    ) else $error("display address out of step with cursor");

    // state never moves while a result is held back
    a_state_holds_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(cursor_field) && $stable(day) && $stable(year)
    ) else $error("field state changed under a stalled result");

    // with the result slot empty the input side can always take an item
    a_no_bubble_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready
    ) else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

>>> src/cfse_in_stage.sv
// ----------------------------------------------------------------------------
// cfse_in_stage
// input register: holds one item until the core takes it
// ----------------------------------------------------------------------------
`default_nettype none

module cfse_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cfse_pkg::item_t item_in,
    input  wire logic            advance,
    output logic                 item_valid,
    output cfse_pkg::item_t      item_out
);

    logic            valid_reg;
    logic            valid_next;
    cfse_pkg::item_t item_reg;

    // free slot, or the held item leaves this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

`default_nettype wire

>>> src/cfse_core.sv
// ----------------------------------------------------------------------------
// cfse_core
// field and cursor registers with the per-item update logic
// ----------------------------------------------------------------------------
`default_nettype none

module cfse_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire cfse_pkg::item_t item,
    output cfse_pkg::fields_t    fields,
    output cfse_pkg::side_t      side_next
);

    cfse_pkg::fields_t state_reg;
    cfse_pkg::fields_t state_next;
    logic              up;
    logic              adjust;

    always_comb
    begin
        state_next = state_reg;
        up         = 1'b0;
        adjust     = 1'b0;
        side_next.commit = 1'b0;

        unique case (cfse_pkg::opcode_t'(item.opcode))
            cfse_pkg::OP_LOAD:
            begin
                state_next.seconds = item.load_seconds;
                state_next.minutes = item.load_minutes;
                state_next.hours   = item.load_hours;
                state_next.day     = item.load_day;
                state_next.month   = item.load_month;
                state_next.weekday = item.load_weekday;
                state_next.year    = item.load_year;
                state_next.cursor  = cfse_pkg::FLD_NONE;
            end
            cfse_pkg::OP_NEXT:
            begin
                state_next.cursor = (state_reg.cursor == cfse_pkg::FLD_SECOND) ?
                                    cfse_pkg::FLD_YEAR : state_reg.cursor + 1'b1;
            end
            cfse_pkg::OP_INC:
            begin
                up     = 1'b1;
                adjust = 1'b1;
            end
            cfse_pkg::OP_DEC:
            begin
                adjust = 1'b1;
            end
            cfse_pkg::OP_CONFIRM:
            begin
                side_next.commit  = 1'b1;
                state_next.cursor = cfse_pkg::FLD_NONE;
            end
            default:
            begin
            end
        endcase

        // only the selected field moves
        if (adjust)
        begin
            unique case (cfse_pkg::field_sel_t'(state_reg.cursor))
                cfse_pkg::FLD_YEAR:
                    state_next.year = cfse_pkg::wrap_step(state_reg.year,
                        7'd0, cfse_pkg::YearMax, up);
                cfse_pkg::FLD_MONTH:
                    state_next.month = 4'(cfse_pkg::wrap_step({3'd0, state_reg.month},
                        cfse_pkg::MonthMin, cfse_pkg::MonthMax, up));
                cfse_pkg::FLD_DAY:
                    state_next.day = 5'(cfse_pkg::wrap_step({2'd0, state_reg.day},
                        cfse_pkg::DayMin, cfse_pkg::month_length(state_reg.month), up));
                cfse_pkg::FLD_WEEKDAY:
                    state_next.weekday = 3'(cfse_pkg::wrap_step({4'd0, state_reg.weekday},
                        cfse_pkg::WeekdayMin, cfse_pkg::WeekdayMax, up));
                cfse_pkg::FLD_HOUR:
                    state_next.hours = 5'(cfse_pkg::wrap_step({2'd0, state_reg.hours},
                        7'd0, cfse_pkg::HourMax, up));
                cfse_pkg::FLD_MINUTE:
                    state_next.minutes = 6'(cfse_pkg::wrap_step({1'b0, state_reg.minutes},
                        7'd0, cfse_pkg::MinSecMax, up));
                cfse_pkg::FLD_SECOND:
                    state_next.seconds = 6'(cfse_pkg::wrap_step({1'b0, state_reg.seconds},
                        7'd0, cfse_pkg::MinSecMax, up));
                default:
                begin
                end
            endcase
        end

        side_next.display_address = cfse_pkg::cursor_address(state_next.cursor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign fields = state_reg;

endmodule

`default_nettype wire

>>> src/cfse_out_stage.sv
// ----------------------------------------------------------------------------
// cfse_out_stage
// result register: valid flag, commit pulse and display address
// ----------------------------------------------------------------------------
`default_nettype none

module cfse_out_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire cfse_pkg::side_t side_next,
    output logic                 advance,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output cfse_pkg::side_t      side
);

    logic            valid_reg;
    logic            valid_next;
    cfse_pkg::side_t side_reg;

    // move an item across when the result slot is empty or being emptied
    assign advance = item_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;

endmodule

`default_nettype wire
